// File: hw/rtl/cld_pkg.sv
package cld_pkg;

  localparam int unsigned WordsPerLine = 8;
  localparam int unsigned QueueDepth   = 2;
  localparam logic [6:0]  LineBytes    = 7'd64;
  localparam logic [15:0] LineNumberMax = 16'hFFFF;
  localparam logic [2:0]  LastWord     = 3'd7;

  typedef enum logic [0:0] {
    ActData  = 1'b0,
    ActClear = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [63:0] chunk_data;
    logic        chunk_last;
  } in_word_t;

  typedef struct packed {
    logic [15:0] line_number;
    logic        is_duplicate;
    logic [7:0]  match_index;
    logic [6:0]  compressed_size;
    logic [15:0] fold_hash;
    logic        store_full;
  } out_word_t;

  // One completed line or one clear, handed from front to back.
  typedef struct packed {
    logic                               clear;
    logic [15:0]                        line_number;
    logic [15:0]                        fold_hash;
    logic [WordsPerLine-1:0][63:0]      words;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkCompare,
    BkWrite,
    BkOutput
  } back_state_e;

  function automatic logic [15:0] word_fold(input logic [63:0] w);
    word_fold = w[63:48] ^ w[47:32] ^ w[31:16] ^ w[15:0];
  endfunction

endpackage

// File: hw/rtl/cld_front.sv
module cld_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cld_pkg::in_word_t in_word_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output cld_pkg::job_t     push_job_o
);

  logic [2:0]  pos_q, pos_d;
  logic [15:0] hash_q, hash_d;
  logic [15:0] seen_q, seen_d;
  logic [cld_pkg::WordsPerLine-1:0][63:0] line_q, line_d, line_new;
  logic [15:0] hash_next;
  logic        fire;

  assign in_ready_o = push_ready_i;
  assign fire       = in_valid_i && push_ready_i;
  assign hash_next  = hash_q ^ cld_pkg::word_fold(in_word_i.chunk_data);

  always_comb begin
    // Start of a line zeroes the words that a short line never fills.
    for (int k = 0; k < cld_pkg::WordsPerLine; k++) begin
      if (3'(k) == pos_q) begin
        line_new[k] = in_word_i.chunk_data;
      end else if (pos_q == 3'd0) begin
        line_new[k] = 64'd0;
      end else begin
        line_new[k] = line_q[k];
      end
    end
  end

  always_comb begin
    pos_d        = pos_q;
    hash_d       = hash_q;
    seen_d       = seen_q;
    line_d       = line_q;
    push_valid_o = 1'b0;
    push_job_o.clear       = (in_word_i.action == cld_pkg::ActClear);
    push_job_o.line_number = seen_q;
    push_job_o.fold_hash   = hash_next;
    push_job_o.words       = line_new;
    if (fire) begin
      if (in_word_i.action == cld_pkg::ActClear) begin
        pos_d        = 3'd0;
        hash_d       = 16'd0;
        seen_d       = 16'd0;
        push_valid_o = 1'b1;
      end else begin
        line_d = line_new;
        if (in_word_i.chunk_last || pos_q == cld_pkg::LastWord) begin
          push_valid_o = 1'b1;
          pos_d        = 3'd0;
          hash_d       = 16'd0;
          if (seen_q != cld_pkg::LineNumberMax) begin
            seen_d = seen_q + 16'd1;
          end
        end else begin
          pos_d  = pos_q + 3'd1;
          hash_d = hash_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 3'd0;
      hash_q <= 16'd0;
      seen_q <= 16'd0;
    end else begin
      pos_q  <= pos_d;
      hash_q <= hash_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
  end

endmodule

// File: hw/rtl/cld_queue.sv
module cld_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cld_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cld_pkg::job_t pop_job_o
);

  localparam int unsigned PtrW = $clog2(cld_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(cld_pkg::QueueDepth + 1);

  cld_pkg::job_t entry_q [cld_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(cld_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: hw/rtl/cld_back.sv
module cld_back #(
  parameter int unsigned LINES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  cld_pkg::job_t      pop_job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cld_pkg::out_word_t out_word_o
);

  localparam int unsigned LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned CW    = $clog2(LINES + 1);
  localparam int unsigned AW    = LW + 3;
  localparam int unsigned Depth = LINES * cld_pkg::WordsPerLine;

  logic [63:0] mem_q [Depth];
  logic [63:0] rdata_q;

  cld_pkg::back_state_e state_q, state_d;
  cld_pkg::job_t        job_q, job_d;
  cld_pkg::out_word_t   out_q, out_d;
  logic [CW-1:0] stored_q, stored_d;
  logic          iss_on_q, iss_on_d;
  logic [LW-1:0] iss_line_q, iss_line_d;
  logic [2:0]    iss_word_q, iss_word_d;
  logic          rd_vld_q, rd_vld_d;
  logic [LW-1:0] rd_line_q, rd_line_d;
  logic [2:0]    rd_word_q, rd_word_d;
  logic          mism_q, mism_d;
  logic          dup_q, dup_d;
  logic [LW-1:0] match_q, match_d;
  logic          full_q, full_d;
  logic [2:0]    wr_word_q, wr_word_d;
  logic          out_valid_q, out_valid_d;

  logic          mem_re, mem_we;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mism_now;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign rd_addr     = {iss_line_q, iss_word_q};
  assign wr_addr     = {stored_q[LW-1:0], wr_word_q};

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    out_d       = out_q;
    stored_d    = stored_q;
    iss_on_d    = iss_on_q;
    iss_line_d  = iss_line_q;
    iss_word_d  = iss_word_q;
    rd_vld_d    = 1'b0;
    rd_line_d   = rd_line_q;
    rd_word_d   = rd_word_q;
    mism_d      = mism_q;
    dup_d       = dup_q;
    match_d     = match_q;
    full_d      = full_q;
    wr_word_d   = wr_word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_ready_o = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mism_now    = 1'b0;

    unique case (state_q)
      cld_pkg::BkIdle: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          job_d = pop_job_i;
          if (pop_job_i.clear) begin
            stored_d = '0;
          end else begin
            full_d     = (stored_q >= CW'(LINES));
            dup_d      = 1'b0;
            match_d    = '0;
            mism_d     = 1'b0;
            iss_line_d = '0;
            iss_word_d = 3'd0;
            wr_word_d  = 3'd0;
            if (stored_q == '0) begin
              state_d = cld_pkg::BkWrite;
            end else begin
              iss_on_d = 1'b1;
              state_d  = cld_pkg::BkCompare;
            end
          end
        end
      end

      cld_pkg::BkCompare: begin
        // Issue one store read per cycle, oldest line first.
        if (iss_on_q) begin
          mem_re     = 1'b1;
          rd_vld_d   = 1'b1;
          rd_line_d  = iss_line_q;
          rd_word_d  = iss_word_q;
          iss_word_d = iss_word_q + 3'd1;
          if (iss_word_q == cld_pkg::LastWord) begin
            if ((CW'(iss_line_q) + CW'(1)) == stored_q) begin
              iss_on_d = 1'b0;
            end else begin
              iss_line_d = iss_line_q + LW'(1);
            end
          end
        end
        // Check the word read last cycle.
        if (rd_vld_q) begin
          mism_now = ((rd_word_q != 3'd0) && mism_q) ||
                     (rdata_q != job_q.words[rd_word_q]);
          mism_d   = mism_now;
          if (rd_word_q == cld_pkg::LastWord) begin
            if (!mism_now) begin
              dup_d    = 1'b1;
              match_d  = rd_line_q;
              iss_on_d = 1'b0;
              rd_vld_d = 1'b0;
              state_d  = cld_pkg::BkWrite;
            end else if ((CW'(rd_line_q) + CW'(1)) == stored_q) begin
              iss_on_d = 1'b0;
              rd_vld_d = 1'b0;
              state_d  = cld_pkg::BkWrite;
            end
          end
        end
      end

      cld_pkg::BkWrite: begin
        if (full_q) begin
          state_d = cld_pkg::BkOutput;
        end else begin
          mem_we    = 1'b1;
          wr_word_d = wr_word_q + 3'd1;
          if (wr_word_q == cld_pkg::LastWord) begin
            stored_d = stored_q + CW'(1);
            state_d  = cld_pkg::BkOutput;
          end
        end
      end

      cld_pkg::BkOutput: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.line_number     = job_q.line_number;
          out_d.is_duplicate    = dup_q;
          out_d.match_index     = dup_q ? 8'(match_q) : 8'd0;
          out_d.compressed_size = dup_q ? 7'd0 : cld_pkg::LineBytes;
          out_d.fold_hash       = job_q.fold_hash;
          out_d.store_full      = full_q;
          state_d               = cld_pkg::BkIdle;
        end
      end

      default: state_d = cld_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cld_pkg::BkIdle;
      stored_q    <= '0;
      iss_on_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stored_q    <= stored_d;
      iss_on_q    <= iss_on_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_q      <= out_d;
    iss_line_q <= iss_line_d;
    iss_word_q <= iss_word_d;
    rd_line_q  <= rd_line_d;
    rd_word_q  <= rd_word_d;
    mism_q     <= mism_d;
    dup_q      <= dup_d;
    match_q    <= match_d;
    full_q     <= full_d;
    wr_word_q  <= wr_word_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= job_q.words[wr_word_q];
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

// File: hw/rtl/cache_line_dedup_engine.sv
// Words are taken one per cycle while the two-entry job queue has room.
// A line's report follows a scan of the stored lines, one store read per cycle, oldest
// first; a match ends the scan early and an empty store skips it. The line is then
// appended unless the store is full. The back end holds one line at a time, and an
// output stall holds it too. A clear resets the store count and gives no report.
// Asynchronous active-low reset clears the store count and the front-end and queue counters, not the store.
module cache_line_dedup_engine #(
  parameter int unsigned LINES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cld_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cld_pkg::out_word_t out_word_o
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  cld_pkg::job_t push_job, pop_job;

  cld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  cld_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  cld_back #(
    .LINES (LINES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: hw/rtl/cld_checker.sv
module cld_checker #(
  parameter int unsigned LINES = 256
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input cld_pkg::out_word_t out_word_i
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_word_i.is_duplicate ? out_word_i.compressed_size == 7'd0
                                             : out_word_i.compressed_size == 7'd64))
    else $error("compressed size disagrees with duplicate flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.is_duplicate |-> out_word_i.match_index == 8'd0)
    else $error("match index set without a duplicate");

  // The store fills only after LINES lines since the last clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.store_full |-> out_word_i.line_number >= 16'(LINES))
    else $error("store reported full too early");

endmodule

bind cache_line_dedup_engine cld_checker #(
  .LINES (LINES)
) u_cld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);
